>>> rtl/hsv_pkg.sv
// Shared constants, types and the sextant channel map for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv_pkg;

   localparam int HUE_W = 15;
   localparam int SV_W = 13;
   localparam int CODE_W = 8;
   localparam int NUM_CHAN = 3;
   localparam int NUM_SEXT = 6;
   localparam int SEXT_W = 3;

   localparam logic [1:0] CHAN_RED = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE = 2'd2;

   localparam int HUE_LIM_DEG = 360;
   localparam int PCT_LIM = 100;
   localparam int SEXT_DEG = 60;
   localparam int CODE_MAX = 255;

   // bits that hold one sextant span (60) and the weight constant (6000) at zero fraction bits
   localparam int DIST_BASE_W = 6;
   localparam int WEIGHT_BASE_W = 13;

   // common denominator is 9375 * 2^(3F + 6)
   localparam int DIV_BASE = 9375;
   localparam int DIV_SHIFT_BASE = 6;
   localparam int QUOT_W = 22;
   localparam int RECIP_K = 35;
   localparam int RECIP_W = 22;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_K) / DIV_BASE);
   localparam int EST_W = CODE_W + 1;

   typedef logic [SEXT_W-1:0] sextant_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_CHROMA,
      SEL_X
   } sel_type;

   typedef struct packed {
      sextant_type sextant;
      logic        out_of_range;
   } ctl_type;

   function automatic sel_type sextant_pick(input sextant_type sextant, input logic [1:0] chan);
      sel_type r;
      sel_type g;
      sel_type b;
      sel_type pick;
      case (sextant)
         3'd0: begin
            r = SEL_CHROMA; g = SEL_X;      b = SEL_ZERO;
         end
         3'd1: begin
            r = SEL_X;      g = SEL_CHROMA; b = SEL_ZERO;
         end
         3'd2: begin
            r = SEL_ZERO;   g = SEL_CHROMA; b = SEL_X;
         end
         3'd3: begin
            r = SEL_ZERO;   g = SEL_X;      b = SEL_CHROMA;
         end
         3'd4: begin
            r = SEL_X;      g = SEL_ZERO;   b = SEL_CHROMA;
         end
         default: begin
            r = SEL_CHROMA; g = SEL_ZERO;   b = SEL_X;
         end
      endcase
      case (chan)
         CHAN_RED:   pick = r;
         CHAN_GREEN: pick = g;
         default:    pick = b;
      endcase
      return pick;
   endfunction

endpackage

>>> rtl/hsv_if.sv
// Valid/ready channel interfaces for pixel requests and colour responses.
`timescale 1ns / 1ps

interface hsv_req_if;
   logic                       valid;
   logic                       ready;
   logic [hsv_pkg::HUE_W-1:0]  hue;
   logic [hsv_pkg::SV_W-1:0]   saturation;
   logic [hsv_pkg::SV_W-1:0]   brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsv_pkg::CODE_W-1:0]  red;
   logic [hsv_pkg::CODE_W-1:0]  green;
   logic [hsv_pkg::CODE_W-1:0]  blue;
   logic                        out_of_range;

   modport source (output valid, red, green, blue, out_of_range, input ready);
   modport sink (input valid, red, green, blue, out_of_range, output ready);
endinterface

>>> rtl/hsv_sextant.sv
// Stage one: range check, sextant of the hue and distance term of the X weight.
`timescale 1ns / 1ps

module hsv_sextant #(
   parameter int FRAC_BITS = 6,
   localparam int DIST_W = hsv_pkg::DIST_BASE_W + FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [hsv_pkg::HUE_W-1:0]  hue,
   input  logic [hsv_pkg::SV_W-1:0]   saturation,
   input  logic [hsv_pkg::SV_W-1:0]   brightness,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hsv_pkg::ctl_type           ctl,
   output logic [DIST_W-1:0]          gap,
   output logic [hsv_pkg::SV_W-1:0]   sat,
   output logic [hsv_pkg::SV_W-1:0]   bri
);

   localparam int XW = hsv_pkg::HUE_W + FRAC_BITS;
   localparam int P = hsv_pkg::SEXT_DEG << FRAC_BITS;
   localparam int unsigned HUE_LIM = hsv_pkg::HUE_LIM_DEG << FRAC_BITS;
   localparam int unsigned PCT = hsv_pkg::PCT_LIM << FRAC_BITS;

   logic [XW-1:0]          hx;
   logic [XW-1:0]          base;
   logic [XW-1:0]          off;
   hsv_pkg::sextant_type   sext;
   hsv_pkg::ctl_type       ctl_in;
   logic [DIST_W-1:0]      gap_in;

   logic                   valid_ff;
   hsv_pkg::ctl_type       ctl_ff;
   logic [DIST_W-1:0]      gap_ff;
   logic [hsv_pkg::SV_W-1:0] sat_ff;
   logic [hsv_pkg::SV_W-1:0] bri_ff;

   always_comb begin
      hx = XW'(hue);
      sext = '0;
      base = '0;
      for (int i = 1; i < hsv_pkg::NUM_SEXT; i++) begin
         if (hx >= XW'(i * P)) begin
            sext = hsv_pkg::SEXT_W'(i);
            base = XW'(i * P);
         end
      end
      off = hx - base;
      if (sext[0]) begin
         gap_in = DIST_W'(off);
      end else begin
         gap_in = DIST_W'(P) - DIST_W'(off);
      end
      ctl_in.sextant = sext;
      ctl_in.out_of_range = (32'(hue) > HUE_LIM) || (32'(saturation) > PCT)
                            || (32'(brightness) > PCT);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ctl_ff  <= ctl_in;
         gap_ff  <= gap_in;
         sat_ff  <= saturation;
         bri_ff  <= brightness;
      end
   end

   assign out_valid = valid_ff;
   assign ctl = ctl_ff;
   assign gap = gap_ff;
   assign sat = sat_ff;
   assign bri = bri_ff;

endmodule

>>> rtl/hsv_weight.sv
// Stages two and three: per-channel weights and the brightness products.
`timescale 1ns / 1ps

module hsv_weight #(
   parameter int FRAC_BITS = 6,
   localparam int DIST_W = hsv_pkg::DIST_BASE_W + FRAC_BITS,
   localparam int WEIGHT_W = hsv_pkg::WEIGHT_BASE_W + 2 * FRAC_BITS,
   localparam int PROD_W = hsv_pkg::SV_W + WEIGHT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hsv_pkg::ctl_type           ctl,
   input  logic [DIST_W-1:0]          gap,
   input  logic [hsv_pkg::SV_W-1:0]   sat,
   input  logic [hsv_pkg::SV_W-1:0]   bri,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic                       out_of_range,
   output logic [PROD_W-1:0]          prod [hsv_pkg::NUM_CHAN]
);

   localparam int P = hsv_pkg::SEXT_DEG << FRAC_BITS;
   localparam int SD_W = (hsv_pkg::SV_W + DIST_W > WEIGHT_W) ?
                         hsv_pkg::SV_W + DIST_W : WEIGHT_W;
   localparam logic [WEIGHT_W-1:0] PL =
      WEIGHT_W'(64'(hsv_pkg::SEXT_DEG * hsv_pkg::PCT_LIM) << (2 * FRAC_BITS));

   logic [SD_W-1:0]      sd;
   logic [SD_W-1:0]      sp;
   logic [WEIGHT_W-1:0]  w_x;
   logic [WEIGHT_W-1:0]  w_0;
   logic [WEIGHT_W-1:0]  weight_in [hsv_pkg::NUM_CHAN];
   logic [PROD_W-1:0]    prod_in [hsv_pkg::NUM_CHAN];

   logic                 valid2_ff;
   logic                 oor2_ff;
   logic [hsv_pkg::SV_W-1:0] bri2_ff;
   logic [WEIGHT_W-1:0]  weight_ff [hsv_pkg::NUM_CHAN];

   logic                 valid3_ff;
   logic                 oor3_ff;
   logic [PROD_W-1:0]    prod_ff [hsv_pkg::NUM_CHAN];

   logic                 ready2;
   logic                 ready3;

   // weights over a common denominator: chroma, X and the zero channel
   always_comb begin
      sd = SD_W'(sat) * SD_W'(gap);
      sp = SD_W'(sat) * SD_W'(P);
      w_x = PL - sd[WEIGHT_W-1:0];
      w_0 = PL - sp[WEIGHT_W-1:0];
      for (int ch = 0; ch < hsv_pkg::NUM_CHAN; ch++) begin
         case (hsv_pkg::sextant_pick(ctl.sextant, 2'(ch)))
            hsv_pkg::SEL_CHROMA: weight_in[ch] = PL;
            hsv_pkg::SEL_X:      weight_in[ch] = w_x;
            default:             weight_in[ch] = w_0;
         endcase
      end
   end

   always_comb begin
      for (int ch = 0; ch < hsv_pkg::NUM_CHAN; ch++) begin
         prod_in[ch] = PROD_W'(bri2_ff) * PROD_W'(weight_ff[ch]);
      end
   end

   assign ready3 = !valid3_ff || out_ready;
   assign ready2 = !valid2_ff || ready3;
   assign in_ready = ready2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready2) begin
            valid2_ff <= in_valid;
         end
         if (ready3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && in_valid) begin
         oor2_ff   <= ctl.out_of_range;
         bri2_ff   <= bri;
         weight_ff <= weight_in;
      end
      if (ready3 && valid2_ff) begin
         oor3_ff <= oor2_ff;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_of_range = oor3_ff;
   assign prod = prod_ff;

endmodule

>>> rtl/hsv_scale.sv
// Stages four to six: scale by 255, divide by the common denominator, output register.
`timescale 1ns / 1ps

module hsv_scale #(
   parameter int FRAC_BITS = 6,
   localparam int PROD_W = 2 * hsv_pkg::SV_W + 2 * FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_out_of_range,
   input  logic [PROD_W-1:0]           prod [hsv_pkg::NUM_CHAN],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [hsv_pkg::CODE_W-1:0]  red,
   output logic [hsv_pkg::CODE_W-1:0]  green,
   output logic [hsv_pkg::CODE_W-1:0]  blue,
   output logic                        out_of_range
);

   localparam int NW = PROD_W + hsv_pkg::CODE_W;
   localparam int SHIFT = 3 * FRAC_BITS + hsv_pkg::DIV_SHIFT_BASE;
   localparam int QR_W = hsv_pkg::QUOT_W + hsv_pkg::RECIP_W;
   localparam int BACK_W = hsv_pkg::QUOT_W + 1;

   logic [NW-1:0]                   scaled [hsv_pkg::NUM_CHAN];
   logic [hsv_pkg::QUOT_W-1:0]      quot_in [hsv_pkg::NUM_CHAN];
   logic [QR_W-1:0]                 qr [hsv_pkg::NUM_CHAN];
   logic [hsv_pkg::EST_W-1:0]       est_in [hsv_pkg::NUM_CHAN];
   logic [BACK_W-1:0]               back [hsv_pkg::NUM_CHAN];
   logic [BACK_W-1:0]               rem [hsv_pkg::NUM_CHAN];
   logic [hsv_pkg::EST_W-1:0]       adj [hsv_pkg::NUM_CHAN];
   logic [hsv_pkg::CODE_W-1:0]      code_in [hsv_pkg::NUM_CHAN];

   logic                            valid4_ff;
   logic                            oor4_ff;
   logic [hsv_pkg::QUOT_W-1:0]      quot4_ff [hsv_pkg::NUM_CHAN];

   logic                            valid5_ff;
   logic                            oor5_ff;
   logic [hsv_pkg::QUOT_W-1:0]      quot5_ff [hsv_pkg::NUM_CHAN];
   logic [hsv_pkg::EST_W-1:0]       est_ff [hsv_pkg::NUM_CHAN];

   logic                            valid6_ff;
   logic                            oor6_ff;
   logic [hsv_pkg::CODE_W-1:0]      code_ff [hsv_pkg::NUM_CHAN];

   logic                            ready4;
   logic                            ready5;
   logic                            ready6;

   // times 255, then drop the power-of-two part of the denominator
   always_comb begin
      for (int ch = 0; ch < hsv_pkg::NUM_CHAN; ch++) begin
         scaled[ch] = (NW'(prod[ch]) << hsv_pkg::CODE_W) - NW'(prod[ch]);
         quot_in[ch] = hsv_pkg::QUOT_W'(scaled[ch] >> SHIFT);
      end
   end

   // reciprocal estimate, low by at most one
   always_comb begin
      for (int ch = 0; ch < hsv_pkg::NUM_CHAN; ch++) begin
         qr[ch] = QR_W'(quot4_ff[ch]) * QR_W'(hsv_pkg::RECIP);
         est_in[ch] = qr[ch][hsv_pkg::RECIP_K +: hsv_pkg::EST_W];
      end
   end

   // correct the estimate, clamp and zero when out of range
   always_comb begin
      for (int ch = 0; ch < hsv_pkg::NUM_CHAN; ch++) begin
         back[ch] = BACK_W'(est_ff[ch]) * BACK_W'(hsv_pkg::DIV_BASE);
         rem[ch] = BACK_W'(quot5_ff[ch]) - back[ch];
         if (rem[ch] >= BACK_W'(hsv_pkg::DIV_BASE)) begin
            adj[ch] = est_ff[ch] + hsv_pkg::EST_W'(1);
         end else begin
            adj[ch] = est_ff[ch];
         end
         if (oor5_ff) begin
            code_in[ch] = '0;
         end else if (adj[ch] > hsv_pkg::EST_W'(hsv_pkg::CODE_MAX)) begin
            code_in[ch] = hsv_pkg::CODE_W'(hsv_pkg::CODE_MAX);
         end else begin
            code_in[ch] = adj[ch][hsv_pkg::CODE_W-1:0];
         end
      end
   end

   assign ready6 = !valid6_ff || out_ready;
   assign ready5 = !valid5_ff || ready6;
   assign ready4 = !valid4_ff || ready5;
   assign in_ready = ready4;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else begin
         if (ready4) begin
            valid4_ff <= in_valid;
         end
         if (ready5) begin
            valid5_ff <= valid4_ff;
         end
         if (ready6) begin
            valid6_ff <= valid5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && in_valid) begin
         oor4_ff  <= in_out_of_range;
         quot4_ff <= quot_in;
      end
      if (ready5 && valid4_ff) begin
         oor5_ff  <= oor4_ff;
         quot5_ff <= quot4_ff;
         est_ff   <= est_in;
      end
      if (ready6 && valid5_ff) begin
         oor6_ff <= oor5_ff;
         code_ff <= code_in;
      end
   end

   assign out_valid = valid6_ff;
   assign out_of_range = oor6_ff;
   assign red = code_ff[hsv_pkg::CHAN_RED];
   assign green = code_ff[hsv_pkg::CHAN_GREEN];
   assign blue = code_ff[hsv_pkg::CHAN_BLUE];

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB pixel converter.
//
//   channel   dir   payload                                   transaction
//   req_if    in    hue[15] saturation[13] brightness[13]     valid & ready
//   rsp_if    out   red[8] green[8] blue[8] out_of_range[1]   valid & ready
//
// Six register stages; a response is valid once its request has passed through all six.
// One pixel per clock sustained while rsp_if.ready stays high.
// Reset clears every stage valid bit; the pipeline holds no other control state.
// Each stage advances when empty or when the stage after it advances, so bubbles close
// while the response is held; req_if.ready drops only with all six stages full.
`timescale 1ns / 1ps

module hsv_to_rgb_converter #(
   parameter int FRAC_BITS = 6
) (
   input  logic      clock,
   input  logic      reset,
   hsv_req_if.sink   req_if,
   hsv_rsp_if.source rsp_if
);

   localparam int DIST_W = hsv_pkg::DIST_BASE_W + FRAC_BITS;
   localparam int PROD_W = 2 * hsv_pkg::SV_W + 2 * FRAC_BITS;

   logic                      s1_valid;
   logic                      s1_ready;
   hsv_pkg::ctl_type          s1_ctl;
   logic [DIST_W-1:0]         s1_gap;
   logic [hsv_pkg::SV_W-1:0]  s1_sat;
   logic [hsv_pkg::SV_W-1:0]  s1_bri;

   logic                      s3_valid;
   logic                      s3_ready;
   logic                      s3_oor;
   logic [PROD_W-1:0]         s3_prod [hsv_pkg::NUM_CHAN];

   hsv_sextant #(
      .FRAC_BITS(FRAC_BITS)
   ) u_sextant (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .hue        (req_if.hue),
      .saturation (req_if.saturation),
      .brightness (req_if.brightness),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .ctl        (s1_ctl),
      .gap        (s1_gap),
      .sat        (s1_sat),
      .bri        (s1_bri)
   );

   hsv_weight #(
      .FRAC_BITS(FRAC_BITS)
   ) u_weight (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .ctl          (s1_ctl),
      .gap          (s1_gap),
      .sat          (s1_sat),
      .bri          (s1_bri),
      .out_valid    (s3_valid),
      .out_ready    (s3_ready),
      .out_of_range (s3_oor),
      .prod         (s3_prod)
   );

   hsv_scale #(
      .FRAC_BITS(FRAC_BITS)
   ) u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s3_valid),
      .in_ready        (s3_ready),
      .in_out_of_range (s3_oor),
      .prod            (s3_prod),
      .out_valid       (rsp_if.valid),
      .out_ready       (rsp_if.ready),
      .red             (rsp_if.red),
      .green           (rsp_if.green),
      .blue            (rsp_if.blue),
      .out_of_range    (rsp_if.out_of_range)
   );

   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.out_of_range |->
         rsp_if.red == '0 && rsp_if.green == '0 && rsp_if.blue == '0)
      else $error("out-of-range response carries a non-zero colour");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid && !rsp_if.ready)
      else $error("request stalled while the response side is free");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid straight after reset");

endmodule

>>> test/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for the HSV to RGB converter: directed table, then random pixels.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

   localparam int FRAC_BITS = 6;
   localparam int HUE_TOP = hsv_pkg::HUE_LIM_DEG << FRAC_BITS;
   localparam int PCT_TOP = hsv_pkg::PCT_LIM << FRAC_BITS;
   localparam int SEXT_SPAN = hsv_pkg::SEXT_DEG << FRAC_BITS;
   localparam int RANDOM_PIXELS = 2000;
   localparam int NUM_DIRECTED = 18;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AFTER = 500;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef logic [hsv_pkg::HUE_W-1:0] hue_type;
   typedef logic [hsv_pkg::SV_W-1:0] pct_type;

   typedef struct packed {
      logic [hsv_pkg::CODE_W-1:0] red;
      logic [hsv_pkg::CODE_W-1:0] green;
      logic [hsv_pkg::CODE_W-1:0] blue;
      logic                       out_of_range;
   } colour_type;

   typedef struct packed {
      hue_type    hue;
      pct_type    saturation;
      pct_type    brightness;
      logic       typed;
      colour_type colour;
   } pixel_row_type;

   logic clock = 1'b0;
   logic reset;
   longint cycle_count = 0;
   int colour_errors = 0;
   int colours_seen = 0;
   colour_type pending_colours[$];
   pixel_row_type directed_rows[NUM_DIRECTED];

   hsv_req_if req_if();
   hsv_rsp_if rsp_if();

   hsv_to_rgb_converter #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic colour_type rgb_from_hsv(input hue_type h_in, input pct_type s_in,
                                               input pct_type v_in);
      longint unsigned h, s, v, one, span, den, t, hue_gap, c_num, x_num, m_num, num, code;
      int sext;
      logic [1:0] c_chan;
      logic [1:0] x_chan;
      logic [hsv_pkg::CODE_W-1:0] codes[hsv_pkg::NUM_CHAN];
      colour_type res;
      h = h_in;
      s = s_in;
      v = v_in;
      res = '0;
      if (h > HUE_TOP || s > PCT_TOP || v > PCT_TOP) begin
         res.out_of_range = 1'b1;
         return res;
      end
      one = 64'd1 << FRAC_BITS;
      span = SEXT_SPAN;
      den = 64'd10000 * one * one * span;
      sext = int'(h / span);
      if (sext > hsv_pkg::NUM_SEXT - 1) sext = hsv_pkg::NUM_SEXT - 1;
      t = h % (2 * span);
      hue_gap = (t >= span) ? (t - span) : (span - t);
      c_num = s * v * span;
      x_num = s * v * (span - hue_gap);
      m_num = (v * PCT_TOP - s * v) * span;
      case (sext)
         0: begin
            c_chan = hsv_pkg::CHAN_RED; x_chan = hsv_pkg::CHAN_GREEN;
         end
         1: begin
            c_chan = hsv_pkg::CHAN_GREEN; x_chan = hsv_pkg::CHAN_RED;
         end
         2: begin
            c_chan = hsv_pkg::CHAN_GREEN; x_chan = hsv_pkg::CHAN_BLUE;
         end
         3: begin
            c_chan = hsv_pkg::CHAN_BLUE; x_chan = hsv_pkg::CHAN_GREEN;
         end
         4: begin
            c_chan = hsv_pkg::CHAN_BLUE; x_chan = hsv_pkg::CHAN_RED;
         end
         default: begin
            c_chan = hsv_pkg::CHAN_RED; x_chan = hsv_pkg::CHAN_BLUE;
         end
      endcase
      for (int ch = 0; ch < hsv_pkg::NUM_CHAN; ch++) begin
         if (ch == c_chan) num = c_num;
         else if (ch == x_chan) num = x_num;
         else num = 0;
         code = ((num + m_num) * 64'(hsv_pkg::CODE_MAX)) / den;
         if (code > hsv_pkg::CODE_MAX) code = hsv_pkg::CODE_MAX;
         codes[ch] = code[hsv_pkg::CODE_W-1:0];
      end
      res.red = codes[hsv_pkg::CHAN_RED];
      res.green = codes[hsv_pkg::CHAN_GREEN];
      res.blue = codes[hsv_pkg::CHAN_BLUE];
      return res;
   endfunction

   // mostly short gaps, a few long ones, and quiet stretches with none
   function automatic int idle_cycles();
      int r;
      if (cycle_count[9:8] == 2'b00) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic pct_type pick_pct();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return pct_type'(PCT_TOP);
      return pct_type'($urandom_range(0, PCT_TOP));
   endfunction

   task automatic send_pixel(input hue_type h, input pct_type s, input pct_type v,
                             input colour_type due);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.hue <= h;
      req_if.saturation <= s;
      req_if.brightness <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_colours = {pending_colours, due};
   endtask

   task automatic check_colour();
      colour_type due;
      if (pending_colours.size() == 0) begin
         $error("unexpected transaction: red %0d green %0d blue %0d out_of_range %0b",
                rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.out_of_range);
         colour_errors++;
         return;
      end
      due = pending_colours.pop_front();
      if (rsp_if.red !== due.red) begin
         $error("red: expected %0d, got %0d", due.red, rsp_if.red);
         colour_errors++;
      end
      if (rsp_if.green !== due.green) begin
         $error("green: expected %0d, got %0d", due.green, rsp_if.green);
         colour_errors++;
      end
      if (rsp_if.blue !== due.blue) begin
         $error("blue: expected %0d, got %0d", due.blue, rsp_if.blue);
         colour_errors++;
      end
      if (rsp_if.out_of_range !== due.out_of_range) begin
         $error("out_of_range: expected %0b, got %0b", due.out_of_range, rsp_if.out_of_range);
         colour_errors++;
      end
   endtask

   // receiver: check at the edge, then stall at random, once for a long stretch
   initial begin
      int stall_left;
      bit long_hold_done;
      stall_left = 0;
      long_hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            check_colour();
            colours_seen++;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (!long_hold_done && colours_seen >= LONG_HOLD_AFTER) begin
            stall_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else begin
            stall_left = idle_cycles();
         end
         rsp_if.ready <= (stall_left == 0);
      end
   end

   initial begin
      hue_type h;
      pct_type s;
      pct_type v;
      int r;
      int sext;
      directed_rows = '{
         '{15'd0,     13'd0,    13'd0,    1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
         '{15'd0,     13'd0,    13'd6400, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
         '{15'd0,     13'd6400, 13'd6400, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
         '{15'd7680,  13'd6400, 13'd6400, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
         '{15'd15360, 13'd6400, 13'd6400, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
         '{15'd23040, 13'd6400, 13'd6400, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
         '{15'd0,     13'd6400, 13'd0,    1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
         '{15'd3840,  13'd6400, 13'd6400, 1'b0, '0},
         '{15'd11520, 13'd5000, 13'd6400, 1'b0, '0},
         '{15'd19200, 13'd3200, 13'd4800, 1'b0, '0},
         '{15'd23039, 13'd6400, 13'd6400, 1'b0, '0},
         '{15'd3839,  13'd6400, 13'd6400, 1'b0, '0},
         '{15'd1,     13'd3200, 13'd5000, 1'b0, '0},
         '{15'd12345, 13'd4000, 13'd6400, 1'b0, '0},
         '{15'd23041, 13'd0,    13'd0,    1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
         '{15'd0,     13'd6401, 13'd0,    1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
         '{15'd0,     13'd0,    13'd6401, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
         '{15'd32767, 13'd8191, 13'd8191, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}}
      };
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.hue <= '0;
      req_if.saturation <= '0;
      req_if.brightness <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].hue, directed_rows[i].saturation,
                    directed_rows[i].brightness,
                    directed_rows[i].typed ? directed_rows[i].colour :
                    rgb_from_hsv(directed_rows[i].hue, directed_rows[i].saturation,
                                 directed_rows[i].brightness));
      end

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            h = hue_type'($urandom_range(0, (1 << hsv_pkg::HUE_W) - 1));
            s = pct_type'($urandom_range(0, (1 << hsv_pkg::SV_W) - 1));
            v = pct_type'($urandom_range(0, (1 << hsv_pkg::SV_W) - 1));
         end else if (r < 30) begin
            sext = $urandom_range(0, hsv_pkg::NUM_SEXT);
            h = hue_type'(sext * SEXT_SPAN + $urandom_range(0, 6) - 3);
            if (sext == 0 && h > HUE_TOP) h = '0;
            if (h > HUE_TOP) h = hue_type'(HUE_TOP);
            s = pick_pct();
            v = pick_pct();
         end else begin
            h = hue_type'($urandom_range(0, HUE_TOP));
            s = pick_pct();
            v = pick_pct();
         end
         send_pixel(h, s, v, rgb_from_hsv(h, s, v));
      end
      req_if.valid <= 1'b0;

      while (pending_colours.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (colour_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/hsv_pkg.sv
rtl/hsv_if.sv
rtl/hsv_sextant.sv
rtl/hsv_weight.sv
rtl/hsv_scale.sv
rtl/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
